// ----- rtl/core/crcfr_pkg.sv -----
// Shared types, constants and the CRC-16/CCITT byte update for the frame receiver.
`timescale 1ns / 1ps

package crcfr_pkg;

    localparam int RX_W       = 8;
    localparam int SYNC_W     = 16;
    localparam int LIMIT_W    = 11;
    localparam int CRC_W      = 16;
    localparam int LEN_W      = 16;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 32;
    localparam int TDATA_W    = 152;
    localparam int TUSER_W    = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CRC_W-1:0]   CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0]   CRC_POLY    = 16'h1021;
    localparam logic [LIMIT_W-1:0] MAX_PAYLOAD = 11'd1024;
    localparam logic [SYNC_W-1:0]  SYNC_RESET  = 16'hAA55;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // register select, taken from paddr[2]
    localparam logic REG_SYNC  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_HEADER  = 3'd1,
        EV_DATA    = 3'd2,
        EV_GOOD    = 3'd3,
        EV_CRC_ERR = 3'd4,
        EV_LEN_ERR = 3'd5
    } event_t;

    typedef struct packed {
        event_t             event_res;
        logic [7:0]         data_byte;
        logic [IDX_W-1:0]   byte_index;
        logic [7:0]         command_code;
        logic [7:0]         frame_flags;
        logic [LEN_W-1:0]   frame_length;
        logic [CRC_W-1:0]   received_crc;
        logic [CRC_W-1:0]   computed_crc;
        logic [CNT_W-1:0]   frame_error_count;
        logic [CNT_W-1:0]   crc_error_count;
    } result_t;

    // MSB-first CRC-16, poly 0x1021, one byte
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    localparam logic [CRC_W-1:0] SYNC_LO_CRC_RESET = crc16_byte(CRC_INIT, SYNC_RESET[7:0]);

endpackage

// ----- rtl/core/crcfr_skid.sv -----
// Output register with skid entry; its ready depends only on registered state.
`timescale 1ns / 1ps

module crcfr_skid (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  crcfr_pkg::result_t   in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output crcfr_pkg::result_t   out_word
);

    logic                main_valid_reg;
    logic                skid_valid_reg;
    crcfr_pkg::result_t  main_word_reg;
    crcfr_pkg::result_t  skid_word_reg;
    logic                push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_word_reg  <= skid_word_reg;
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                main_word_reg  <= in_word;
                main_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b0;
            end
        end else if (push) begin
            skid_word_reg  <= in_word;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

// ----- rtl/core/crc16_frame_receiver_unit.sv -----
// Top level: sync hunt, header parse, payload report and CRC-16 check per byte.
//
//  port group   dir  word contents (low bit first)
//  s_*          in   s_tdata[7:0] rx_byte
//  m_*          out  m_tuser event_res; m_tdata data_byte .. crc_error_count
//  APB          in   0x0 sync_word[15:0], 0x4 payload_limit[10:0]
//
//  One byte per cycle sustained while m_tready stays high; a taken byte goes into the input
//  register, then through the parse/CRC step into the output register or its skid entry.
//  The per-byte CRC-16 update and phase step sit between those two registers.
//  aresetn is synchronous; afterwards all counters are zero and the hunt restarts.
//  A stalled m_tready fills the skid entry; s_tready drops once the skid entry and
//  the input register both hold a word.
`timescale 1ns / 1ps

module crc16_frame_receiver_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // slave stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [crcfr_pkg::RX_W-1:0]            s_tdata,   // [7:0] rx_byte
    // master stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [7:0] data_byte, [17:8] byte_index, [25:18] command_code,
    // [33:26] frame_flags, [49:34] frame_length, [65:50] received_crc,
    // [81:66] computed_crc, [113:82] frame_error_count,
    // [145:114] crc_error_count, [151:146] zero
    output logic [crcfr_pkg::TDATA_W-1:0]         m_tdata,
    output logic [crcfr_pkg::TUSER_W-1:0]         m_tuser,   // [2:0] event_res
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crcfr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [crcfr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [crcfr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    typedef enum logic [2:0] {
        PH_SYNC_LO,
        PH_SYNC_HI,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    // configuration
    logic [crcfr_pkg::SYNC_W-1:0]  sync_reg;
    logic [crcfr_pkg::CRC_W-1:0]   sync_crc_reg;   // CRC after the low sync byte
    logic [crcfr_pkg::LIMIT_W-1:0] limit_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == crcfr_pkg::REG_LIMIT)
                  ? {{(crcfr_pkg::APB_DATA_W-crcfr_pkg::LIMIT_W){1'b0}}, limit_reg}
                  : {{(crcfr_pkg::APB_DATA_W-crcfr_pkg::SYNC_W){1'b0}}, sync_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg     <= crcfr_pkg::SYNC_RESET;
            sync_crc_reg <= crcfr_pkg::SYNC_LO_CRC_RESET;
            limit_reg    <= crcfr_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == crcfr_pkg::REG_SYNC) begin
                sync_reg     <= pwdata[crcfr_pkg::SYNC_W-1:0];
                sync_crc_reg <= crcfr_pkg::crc16_byte(crcfr_pkg::CRC_INIT, pwdata[7:0]);
            end else begin
                limit_reg <= pwdata[crcfr_pkg::LIMIT_W-1:0];
            end
        end
    end

    // input register
    logic                        in_valid_reg;
    logic [crcfr_pkg::RX_W-1:0]  in_byte_reg;
    logic                        ob_ready;
    logic                        advance;

    assign advance  = in_valid_reg && ob_ready;
    assign s_tready = !in_valid_reg || ob_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
            in_byte_reg  <= s_tdata;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // frame state
    phase_t                          phase_reg, phase_next;
    logic [1:0]                      hdr_pos_reg, hdr_pos_next;
    logic [7:0]                      cmd_reg, cmd_next;
    logic [7:0]                      flags_reg, flags_next;
    logic [crcfr_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [crcfr_pkg::LIMIT_W-1:0]   pay_cnt_reg, pay_cnt_next;
    logic [7:0]                      crc_lo_reg, crc_lo_next;
    logic                            crc_seen_reg, crc_seen_next;
    logic [crcfr_pkg::CRC_W-1:0]     crc_reg, crc_next;
    logic [crcfr_pkg::CNT_W-1:0]     frame_err_reg, frame_err_next;
    logic [crcfr_pkg::CNT_W-1:0]     crc_err_reg, crc_err_next;

    crcfr_pkg::event_t               ev;
    logic [7:0]                      res_byte;
    logic [crcfr_pkg::IDX_W-1:0]     res_idx;
    logic [crcfr_pkg::CRC_W-1:0]     res_rcrc;
    logic [crcfr_pkg::CRC_W-1:0]     crc_upd;
    logic [crcfr_pkg::LIMIT_W-1:0]   eff_limit;
    logic [crcfr_pkg::LEN_W-1:0]     len_full;
    logic [crcfr_pkg::LIMIT_W-1:0]   cnt_inc;
    logic [7:0]                      b;
    crcfr_pkg::result_t              res;

    assign b         = in_byte_reg;
    assign crc_upd   = crcfr_pkg::crc16_byte(crc_reg, b);
    assign eff_limit = (limit_reg > crcfr_pkg::MAX_PAYLOAD) ? crcfr_pkg::MAX_PAYLOAD : limit_reg;
    assign len_full  = {b, len_reg[7:0]};
    assign cnt_inc   = pay_cnt_reg + 1'b1;

    always_comb begin
        phase_next     = phase_reg;
        hdr_pos_next   = hdr_pos_reg;
        cmd_next       = cmd_reg;
        flags_next     = flags_reg;
        len_next       = len_reg;
        pay_cnt_next   = pay_cnt_reg;
        crc_lo_next    = crc_lo_reg;
        crc_seen_next  = crc_seen_reg;
        crc_next       = crc_reg;
        frame_err_next = frame_err_reg;
        crc_err_next   = crc_err_reg;
        ev             = crcfr_pkg::EV_NONE;
        res_byte       = 8'h00;
        res_idx        = '0;
        res_rcrc       = '0;
        case (phase_reg)
            PH_SYNC_LO: begin
                if (b == sync_reg[7:0]) begin
                    phase_next = PH_SYNC_HI;
                end
            end
            PH_SYNC_HI: begin
                if (b == sync_reg[15:8]) begin
                    phase_next    = PH_HEADER;
                    hdr_pos_next  = 2'd0;
                    pay_cnt_next  = '0;
                    cmd_next      = 8'h00;
                    flags_next    = 8'h00;
                    len_next      = '0;
                    crc_seen_next = 1'b0;
                    crc_next      = crcfr_pkg::crc16_byte(sync_crc_reg, sync_reg[15:8]);
                end else if (b != sync_reg[7:0]) begin
                    phase_next = PH_SYNC_LO;
                end
            end
            PH_HEADER: begin
                crc_next     = crc_upd;
                hdr_pos_next = hdr_pos_reg + 2'd1;
                case (hdr_pos_reg)
                    2'd0:    cmd_next   = b;
                    2'd1:    flags_next = b;
                    2'd2:    len_next   = {len_reg[15:8], b};
                    default: begin
                        len_next = len_full;
                        if (len_full > {{(crcfr_pkg::LEN_W-crcfr_pkg::LIMIT_W){1'b0}},
                                        eff_limit}) begin
                            ev             = crcfr_pkg::EV_LEN_ERR;
                            frame_err_next = frame_err_reg + 1'b1;
                            phase_next     = PH_SYNC_LO;
                        end else begin
                            ev            = crcfr_pkg::EV_HEADER;
                            pay_cnt_next  = '0;
                            crc_seen_next = 1'b0;
                            phase_next    = (len_full == '0) ? PH_CHECK : PH_PAYLOAD;
                        end
                    end
                endcase
            end
            PH_PAYLOAD: begin
                crc_next     = crc_upd;
                ev           = crcfr_pkg::EV_DATA;
                res_byte     = b;
                res_idx      = pay_cnt_reg[crcfr_pkg::IDX_W-1:0];
                pay_cnt_next = cnt_inc;
                if ({{(crcfr_pkg::LEN_W-crcfr_pkg::LIMIT_W){1'b0}}, cnt_inc} >= len_reg) begin
                    phase_next    = PH_CHECK;
                    crc_seen_next = 1'b0;
                end
            end
            PH_CHECK: begin
                if (!crc_seen_reg) begin
                    crc_lo_next   = b;
                    crc_seen_next = 1'b1;
                end else begin
                    res_rcrc      = {b, crc_lo_reg};
                    crc_seen_next = 1'b0;
                    phase_next    = PH_SYNC_LO;
                    if ({b, crc_lo_reg} == crc_reg) begin
                        ev = crcfr_pkg::EV_GOOD;
                    end else begin
                        ev             = crcfr_pkg::EV_CRC_ERR;
                        crc_err_next   = crc_err_reg + 1'b1;
                        frame_err_next = frame_err_reg + 1'b1;
                    end
                end
            end
            default: begin
                phase_next = PH_SYNC_LO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SYNC_LO;
            hdr_pos_reg   <= 2'd0;
            cmd_reg       <= 8'h00;
            flags_reg     <= 8'h00;
            len_reg       <= '0;
            pay_cnt_reg   <= '0;
            crc_lo_reg    <= 8'h00;
            crc_seen_reg  <= 1'b0;
            crc_reg       <= crcfr_pkg::CRC_INIT;
            frame_err_reg <= '0;
            crc_err_reg   <= '0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            hdr_pos_reg   <= hdr_pos_next;
            cmd_reg       <= cmd_next;
            flags_reg     <= flags_next;
            len_reg       <= len_next;
            pay_cnt_reg   <= pay_cnt_next;
            crc_lo_reg    <= crc_lo_next;
            crc_seen_reg  <= crc_seen_next;
            crc_reg       <= crc_next;
            frame_err_reg <= frame_err_next;
            crc_err_reg   <= crc_err_next;
        end
    end

    always_comb begin
        res.event_res         = ev;
        res.data_byte         = res_byte;
        res.byte_index        = res_idx;
        res.command_code      = cmd_next;
        res.frame_flags       = flags_next;
        res.frame_length      = len_next;
        res.received_crc      = res_rcrc;
        res.computed_crc      = crc_next;
        res.frame_error_count = frame_err_next;
        res.crc_error_count   = crc_err_next;
    end

    crcfr_pkg::result_t out_word;

    crcfr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (advance),
        .in_ready  (ob_ready),
        .in_word   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tuser = out_word.event_res;
    assign m_tdata = {6'b0,
                      out_word.crc_error_count,
                      out_word.frame_error_count,
                      out_word.computed_crc,
                      out_word.received_crc,
                      out_word.frame_length,
                      out_word.frame_flags,
                      out_word.command_code,
                      out_word.byte_index,
                      out_word.data_byte};

    // a CRC mismatch bumps both counters by exactly one
    a_crc_err_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ev == crcfr_pkg::EV_CRC_ERR |=>
            crc_err_reg == $past(crc_err_reg) + 1'b1 &&
            frame_err_reg == $past(frame_err_reg) + 1'b1)
        else $error("crc error did not count in both counters");

    // counters only move when a word is processed
    a_cnt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(crc_err_reg) && $stable(frame_err_reg))
        else $error("error counter moved without a word");

    // payload count never runs past the held length
    a_pay_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |->
            {{(crcfr_pkg::LEN_W-crcfr_pkg::LIMIT_W){1'b0}}, pay_cnt_reg} < len_reg)
        else $error("payload count beyond frame length");

    // input side stalls only while a word is held and the output cannot take it
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && !ob_ready)
        else $error("input stalled without cause");

endmodule

// ----- test/tb_top.sv -----
// Testbench for the CRC-16 frame receiver: byte stimulus, in-order result checking, APB setup.
`timescale 1ns / 1ps

module tb_top;
    import crcfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [APB_ADDR_W-1:0] ADDR_SYNC  = {REG_SYNC, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT = {REG_LIMIT, 2'b00};

    typedef enum logic [2:0] {
        HUNT_LO, HUNT_HI, IN_HEADER, IN_PAYLOAD, IN_CHECK
    } rx_phase_t;

    typedef enum int {FR_GOOD, FR_BADCRC, FR_CUT} frame_kind_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [RX_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic [TUSER_W-1:0]    m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // register copies
    logic [SYNC_W-1:0]  cfg_sync;
    logic [LIMIT_W-1:0] cfg_limit;

    // deframer state
    rx_phase_t          ph;
    logic [1:0]         hdr_pos;
    logic [7:0]         cmd_q;
    logic [7:0]         flags_q;
    logic [LEN_W-1:0]   len_q;
    int unsigned        pay_cnt;
    logic [7:0]         crc_lo_q;
    bit                 crc_lo_seen;
    logic [CRC_W-1:0]   crc_q;
    logic [CNT_W-1:0]   frame_err_q;
    logic [CNT_W-1:0]   crc_err_q;

    result_t     frame_events_due[$];
    result_t     want;
    int unsigned mismatches = 0;
    int unsigned words_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;
    int          hold_cycles = 0;
    bit          src_idle_en = 1'b1;
    bit          snk_idle_en = 1'b1;

    crc16_frame_receiver_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 100) $display("ERROR: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("word %0d %s: got %0h expected %0h",
                                      words_seen, name, got, exp_val));
    endtask

    // MSB-first CRC-16, one data bit per step
    function automatic logic [CRC_W-1:0] ccitt_step(input logic [CRC_W-1:0] c,
                                                    input logic [7:0] b);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[CRC_W-1] ^ b[i];
            r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return r;
    endfunction

    function automatic logic [LIMIT_W-1:0] accepted_length_max();
        return (cfg_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_limit;
    endfunction

    task automatic deframer_reset();
        cfg_sync    = SYNC_RESET;
        cfg_limit   = LIMIT_RESET;
        ph          = HUNT_LO;
        hdr_pos     = '0;
        cmd_q       = '0;
        flags_q     = '0;
        len_q       = '0;
        pay_cnt     = 0;
        crc_lo_q    = '0;
        crc_lo_seen = 1'b0;
        crc_q       = CRC_INIT;
        frame_err_q = '0;
        crc_err_q   = '0;
    endtask

    // advances the deframer by one received byte, returns the word it reports
    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t          r;
        logic [7:0]       lo;
        logic [7:0]       hi;
        logic [CRC_W-1:0] rx_fcs;
        lo     = cfg_sync[7:0];
        hi     = cfg_sync[15:8];
        r      = '0;
        rx_fcs = '0;
        r.event_res = EV_NONE;
        case (ph)
            HUNT_LO: begin
                if (b == lo) ph = HUNT_HI;
            end
            HUNT_HI: begin
                if (b == hi) begin
                    ph          = IN_HEADER;
                    hdr_pos     = '0;
                    pay_cnt     = 0;
                    cmd_q       = '0;
                    flags_q     = '0;
                    len_q       = '0;
                    crc_lo_seen = 1'b0;
                    crc_q       = ccitt_step(ccitt_step(CRC_INIT, lo), hi);
                end else if (b != lo) begin
                    ph = HUNT_LO;
                end
            end
            IN_HEADER: begin
                crc_q = ccitt_step(crc_q, b);
                case (hdr_pos)
                    2'd0: cmd_q = b;
                    2'd1: flags_q = b;
                    2'd2: len_q[7:0] = b;
                    default: len_q[15:8] = b;
                endcase
                hdr_pos = hdr_pos + 2'd1;
                if (hdr_pos == 2'd0) begin
                    if (len_q > accepted_length_max()) begin
                        r.event_res = EV_LEN_ERR;
                        frame_err_q = frame_err_q + 1;
                        ph          = HUNT_LO;
                    end else begin
                        r.event_res = EV_HEADER;
                        pay_cnt     = 0;
                        crc_lo_seen = 1'b0;
                        ph          = (len_q == 0) ? IN_CHECK : IN_PAYLOAD;
                    end
                end
            end
            IN_PAYLOAD: begin
                crc_q        = ccitt_step(crc_q, b);
                r.event_res  = EV_DATA;
                r.data_byte  = b;
                r.byte_index = pay_cnt[IDX_W-1:0];
                pay_cnt++;
                if (pay_cnt >= len_q) begin
                    ph          = IN_CHECK;
                    crc_lo_seen = 1'b0;
                end
            end
            default: begin
                if (!crc_lo_seen) begin
                    crc_lo_q    = b;
                    crc_lo_seen = 1'b1;
                end else begin
                    rx_fcs      = {b, crc_lo_q};
                    crc_lo_seen = 1'b0;
                    if (rx_fcs == crc_q) begin
                        r.event_res = EV_GOOD;
                    end else begin
                        r.event_res = EV_CRC_ERR;
                        crc_err_q   = crc_err_q + 1;
                        frame_err_q = frame_err_q + 1;
                    end
                    ph = HUNT_LO;
                end
            end
        endcase
        r.command_code      = cmd_q;
        r.frame_flags       = flags_q;
        r.frame_length      = len_q;
        r.received_crc      = rx_fcs;
        r.computed_crc      = crc_q;
        r.frame_error_count = frame_err_q;
        r.crc_error_count   = crc_err_q;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (src_idle_en && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        frame_events_due.push_back(deframe_byte(b));
        bytes_sent++;
    endtask

    // stop sending, then let every pending word come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frame_events_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write, then read back; the block is drained first
    task automatic set_reg(input logic sel, input logic [31:0] value);
        logic [APB_DATA_W-1:0] rd_exp;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (sel == REG_SYNC) ? ADDR_SYNC : ADDR_LIMIT;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == REG_SYNC) begin
            cfg_sync = value[SYNC_W-1:0];
            rd_exp   = {{(APB_DATA_W-SYNC_W){1'b0}}, cfg_sync};
        end else begin
            cfg_limit = value[LIMIT_W-1:0];
            rd_exp    = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_limit};
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== rd_exp)
            report_mismatch($sformatf("register %0d read: got %0h expected %0h",
                                      sel, prdata, rd_exp));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // lead_lo: number of low sync bytes sent first (0 when the hunt already has it)
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] flags,
                              input logic [15:0] len, input frame_kind_t kind,
                              input int lead_lo);
        logic [7:0]       fb[$];
        logic [31:0]      hdr;
        logic [CRC_W-1:0] fcs;
        logic [7:0]       x;
        int               n_pay;
        fb  = {};
        for (int i = 0; i < lead_lo; i++) fb.push_back(cfg_sync[7:0]);
        fb.push_back(cfg_sync[15:8]);
        fcs = ccitt_step(ccitt_step(CRC_INIT, cfg_sync[7:0]), cfg_sync[15:8]);
        hdr = {len[15:8], len[7:0], flags, cmd};
        for (int i = 0; i < 4; i++) begin
            fb.push_back(hdr[8*i +: 8]);
            fcs = ccitt_step(fcs, hdr[8*i +: 8]);
        end
        // over-limit length: the block goes back to hunting after the header
        if (len <= accepted_length_max()) begin
            n_pay = (kind == FR_CUT) ? int'($urandom_range(len)) : int'(len);
            for (int i = 0; i < n_pay; i++) begin
                x = 8'($urandom_range(255));
                fb.push_back(x);
                fcs = ccitt_step(fcs, x);
            end
            if (kind != FR_CUT) begin
                if (kind == FR_BADCRC) fcs = fcs ^ 16'($urandom_range(65535, 1));
                fb.push_back(fcs[7:0]);
                fb.push_back(fcs[15:8]);
            end
        end
        foreach (fb[i]) send_byte(fb[i]);
    endtask

    task automatic run_random_phase(input int n_bytes);
        int unsigned stop_at;
        int          pick;
        int          lim;
        int          span;
        logic [15:0] len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            lim  = int'(accepted_length_max());
            span = ($urandom_range(7) == 0) ? 80 : 12;
            if (span > lim) span = lim;
            if (pick < 80) begin
                len = 16'($urandom_range(span));
                send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
                           (pick < 68) ? FR_GOOD : FR_BADCRC,
                           ($urandom_range(9) == 0) ? $urandom_range(4, 2) : 1);
            end else if (pick < 88) begin
                len = $urandom_range(1) ? 16'(lim + 1) : 16'($urandom_range(65535, lim + 1));
                send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, FR_GOOD, 1);
            end else if (pick < 93) begin
                len = 16'($urandom_range(span));
                send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, FR_CUT, 1);
            end else begin
                repeat ($urandom_range(6, 1))
                    send_byte($urandom_range(2) == 0 ? cfg_sync[7:0] : 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_directed();
        // repeated low sync byte keeps waiting, an unrelated byte restarts the hunt
        send_byte(SYNC_RESET[7:0]);
        send_byte(SYNC_RESET[7:0]);
        send_byte(8'h13);
        send_frame(8'hFF, 8'h00, 16'd0, FR_GOOD, 1);
        send_frame(8'h00, 8'hFF, 16'd1, FR_BADCRC, 1);
        send_frame(8'h5A, 8'hA5, 16'hFFFF, FR_GOOD, 1);
    endtask

    task automatic test_limits();
        set_reg(REG_LIMIT, 32'd0);
        send_frame(8'h01, 8'h02, 16'd0, FR_GOOD, 1);
        send_frame(8'h03, 8'h04, 16'd1, FR_GOOD, 1);
        // limit above the build maximum is clipped to it
        set_reg(REG_LIMIT, 32'd2047);
        send_frame(8'h05, 8'h06, 16'd1025, FR_GOOD, 1);
        send_frame(8'h07, 8'h08, 16'd1024, FR_GOOD, 1);
    endtask

    // register writes landing while a frame is half parsed
    task automatic test_midframe_config();
        set_reg(REG_SYNC, 32'h0000_0000);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hC3);
        send_byte(8'h3C);
        set_reg(REG_LIMIT, 32'd3);
        send_byte(8'h04);
        send_byte(8'h00);
        set_reg(REG_SYNC, 32'h0000_FFFF);
        send_byte(8'hFF);
        set_reg(REG_SYNC, 32'h0000_1234);
        send_frame(8'h9A, 8'hBC, 16'd2, FR_GOOD, 0);
    endtask

    task automatic test_backpressure();
        int unsigned stop_at;
        set_reg(REG_SYNC, {16'h0000, SYNC_RESET});
        set_reg(REG_LIMIT, 32'd16);
        src_idle_en = 1'b0;
        hold_cycles <= 300;
        stop_at = bytes_sent + 150;
        while (bytes_sent < stop_at)
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                       16'($urandom_range(16)), FR_GOOD, 1);
        src_idle_en = 1'b1;
        settle();
    endtask

    task automatic test_random();
        set_reg(REG_SYNC, $urandom_range(65535));
        set_reg(REG_LIMIT, $urandom_range(40));
        run_random_phase(120);
        // equal sync bytes; first part runs with no idling on either side
        set_reg(REG_SYNC, {16'h0000, {2{8'($urandom_range(255))}}});
        set_reg(REG_LIMIT, 32'd2047);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        run_random_phase(100);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        run_random_phase(50);
        // junk in the unused upper bits of the write data
        set_reg(REG_SYNC, ($urandom() & 32'hFFFF_0000) | {16'h0000, SYNC_RESET});
        set_reg(REG_LIMIT, ($urandom() & 32'hFFFF_F800) | {21'h000000, LIMIT_RESET});
        run_random_phase(120);
    endtask

    // result side: random stall, one long hold-off on request, in-order compare
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_events_due.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with no byte pending", words_seen));
            end else begin
                want = frame_events_due.pop_front();
                check_field("event_res", 32'(m_tuser), 32'(want.event_res));
                check_field("data_byte", 32'(m_tdata[7:0]), 32'(want.data_byte));
                check_field("byte_index", 32'(m_tdata[17:8]), 32'(want.byte_index));
                check_field("command_code", 32'(m_tdata[25:18]), 32'(want.command_code));
                check_field("frame_flags", 32'(m_tdata[33:26]), 32'(want.frame_flags));
                check_field("frame_length", 32'(m_tdata[49:34]), 32'(want.frame_length));
                check_field("received_crc", 32'(m_tdata[65:50]), 32'(want.received_crc));
                check_field("computed_crc", 32'(m_tdata[81:66]), 32'(want.computed_crc));
                check_field("frame_error_count", m_tdata[113:82], want.frame_error_count);
                check_field("crc_error_count", m_tdata[145:114], want.crc_error_count);
                check_field("tdata pad", 32'(m_tdata[151:146]), '0);
            end
            words_seen++;
        end
        if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= snk_idle_en ? ($urandom_range(99) >= 34) : 1'b1;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        m_tready <= 1'b0;
        deframer_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_limits();
        test_midframe_config();
        test_backpressure();
        test_random();
        settle();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/crcfr_pkg.sv
rtl/core/crcfr_skid.sv
rtl/core/crc16_frame_receiver_unit.sv
test/tb_top.sv
